### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rwst_pkg.sv
// ----------------------------------------------------------------------------
// rwst_pkg
// Widths, codes and defaults of the random-walk spanning-tree core.
// ----------------------------------------------------------------------------
package rwst_pkg;

    localparam int SITE_W       = 12;
    localparam int SIZE_W       = 13;
    localparam int TIME_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int DIR_W        = 2;
    localparam int SIDE_REG_W   = 7;
    localparam int APB_AW       = 2;
    localparam int APB_DW       = 32;
    localparam int MAX_SIDE_DEF = 64;
    localparam int MIN_SIDE     = 2;

    localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 7'd64;
    localparam logic [APB_AW-1:0]     ADDR_SIDE  = 2'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_READ  = 2'd2
    } t_func;

    typedef enum logic [DIR_W-1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

endpackage

### rtl/core/random_walk_spanning_tree_core.sv
// ----------------------------------------------------------------------------
// random_walk_spanning_tree_core
// Random-walk spanning-tree builder on a periodic square lattice. Forward
// parents and backward exits live in two synchronous site memories.
// ----------------------------------------------------------------------------
//  channel  | handshake                | word
//  ---------+--------------------------+-----------------------------------
//  request  | i_in_valid / o_in_stall  | func, site, direction
//  result   | o_out_valid / i_out_stall| site, parent, flags, size, time
//  config   | psel/penable/pwrite      | lattice side at byte address 0
//
//  Step and read: accept with memory read, then update and result.
//  Start: a clearing pass over all MAX_SIDE*MAX_SIDE sites, then the column division, update and result.
//  Reset: a clearing pass over all MAX_SIDE*MAX_SIDE sites (4096 by default).
//  Side write: the input stalls while the walker column is recomputed. A
//  stalled result holds in the output register while the next request is
//  accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module random_walk_spanning_tree_core
    import rwst_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [SITE_W-1:0]     i_site,
    input  logic [DIR_W-1:0]      i_direction,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SITE_W-1:0]     o_current_site,
    output logic [SITE_W-1:0]     o_parent_site,
    output logic                  o_first_visit,
    output logic                  o_entry_valid,
    output logic [SITE_W-1:0]     o_exit_site,
    output logic [SIZE_W-1:0]     o_tree_size,
    output logic [TIME_W-1:0]     o_cover_time,
    output logic                  o_covered,
    output logic                  o_bad_request,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int Depth   = MAX_SIDE * MAX_SIDE;
    localparam int AddrW   = $clog2(Depth);
    localparam int CntW    = $clog2(Depth + 1);
    localparam int SideW   = $clog2(MAX_SIDE + 1);
    localparam int CmpW    = ((CntW > SITE_W) ? CntW : SITE_W) + 1;
    localparam int DivCntW = $clog2(AddrW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_EXEC
    } t_state;

    t_state                  r_state;
    logic [SIDE_REG_W-1:0]   r_side;
    logic [CntW-1:0]         r_ns;
    logic [AddrW-1:0]        r_walker;
    logic [SideW-1:0]        r_col;
    logic [CntW-1:0]         r_count;
    logic [TIME_W-1:0]       r_steps;
    logic                    r_started;
    logic                    r_col_dirty;
    logic                    r_start_pend;
    logic [AddrW-1:0]        r_clr_addr;
    logic [DivCntW-1:0]      r_div_cnt;
    logic [AddrW-1:0]        r_div_src;
    logic [SideW-1:0]        r_rem;
    t_func                   r_func;
    logic [SITE_W-1:0]       r_site;
    logic [AddrW-1:0]        r_to;
    logic [SideW-1:0]        r_to_col;

    logic                    r_o_valid;
    logic [SITE_W-1:0]       r_o_current;
    logic [SITE_W-1:0]       r_o_parent;
    logic                    r_o_first;
    logic                    r_o_entry;
    logic [SITE_W-1:0]       r_o_exit;
    logic [SIZE_W-1:0]       r_o_size;
    logic [TIME_W-1:0]       r_o_time;
    logic                    r_o_covered;
    logic                    r_o_bad;

    logic [AddrW:0]          r_fwd_mem [Depth];
    logic [AddrW:0]          r_bwd_mem [Depth];
    logic [AddrW:0]          r_fwd_rdata;
    logic [AddrW:0]          r_bwd_rdata;

    logic                    in_accept;
    logic                    cfg_write;
    logic                    out_free;
    logic                    exec_fire;
    logic [SideW-1:0]        side_use;
    logic [CmpW-1:0]         w_x;
    logic [CmpW-1:0]         s_x;
    logic [CmpW-1:0]         n_x;
    logic [CmpW-1:0]         sum_up;
    logic [CmpW-1:0]         nb_x;
    logic [SideW-1:0]        nb_col;
    logic [AddrW-1:0]        rd_addr;
    logic [SideW:0]          div_t;
    logic [SideW:0]          div_next;
    logic                    site_ok;

    logic [AddrW-1:0]        n_walker;
    logic [SideW-1:0]        n_col;
    logic [CntW-1:0]         n_count;
    logic [TIME_W-1:0]       n_steps;
    logic                    n_started;
    logic [AddrW-1:0]        res_parent;
    logic                    res_first;
    logic                    res_entry;
    logic [AddrW-1:0]        res_exit;
    logic                    res_bad;
    logic                    x_fwd_we;
    logic [AddrW-1:0]        x_fwd_addr;
    logic [AddrW:0]          x_fwd_data;
    logic                    x_bwd_we;
    logic [AddrW-1:0]        x_bwd_addr;
    logic [AddrW:0]          x_bwd_data;
    logic                    fwd_we;
    logic [AddrW-1:0]        fwd_waddr;
    logic [AddrW:0]          fwd_wdata;
    logic                    bwd_we;
    logic [AddrW-1:0]        bwd_waddr;
    logic [AddrW:0]          bwd_wdata;

    assign o_in_stall = !(r_state == S_IDLE && !r_col_dirty);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_o_valid || !i_out_stall;
    assign exec_fire  = (r_state == S_EXEC) && out_free;
    assign cfg_write  = psel && penable && pwrite && pready && (paddr == ADDR_SIDE);
    assign pready     = 1'b1;
    assign prdata     = (paddr == ADDR_SIDE) ? APB_DW'(r_side) : '0;

    always_comb begin
        if (r_side < SIDE_REG_W'(MIN_SIDE)) begin
            side_use = SideW'(MIN_SIDE);
        end else if (int'(r_side) > MAX_SIDE) begin
            side_use = SideW'(MAX_SIDE);
        end else begin
            side_use = SideW'(r_side);
        end
    end

    // neighbor of the walker for the offered direction
    always_comb begin
        w_x    = CmpW'(r_walker);
        s_x    = CmpW'(side_use);
        n_x    = CmpW'(r_ns);
        sum_up = w_x + s_x;
        nb_col = r_col;
        case (t_dir'(i_direction))
            DIR_RIGHT: begin
                if (CmpW'(r_col) + CmpW'(1) == s_x) begin
                    nb_x   = w_x + CmpW'(1) - s_x;
                    nb_col = '0;
                end else begin
                    nb_x   = w_x + CmpW'(1);
                    nb_col = r_col + SideW'(1);
                end
            end
            DIR_LEFT: begin
                if (r_col == '0) begin
                    nb_x   = w_x + s_x - CmpW'(1);
                    nb_col = side_use - SideW'(1);
                end else begin
                    nb_x   = w_x - CmpW'(1);
                    nb_col = r_col - SideW'(1);
                end
            end
            DIR_UP: begin
                nb_x = (sum_up >= n_x) ? sum_up - n_x : sum_up;
            end
            default: begin
                nb_x = (w_x < s_x) ? w_x + n_x - s_x : w_x - s_x;
            end
        endcase
    end

    assign rd_addr = (i_func == FUNC_READ) ? AddrW'(i_site) : AddrW'(nb_x);

    // one restoring remainder step per cycle
    assign div_t    = {r_rem, r_div_src[AddrW-1]};
    assign div_next = (div_t >= {1'b0, side_use}) ? div_t - {1'b0, side_use} : div_t;

    assign site_ok = CmpW'(r_site) < CmpW'(r_ns);

    always_comb begin
        n_walker   = r_walker;
        n_col      = r_col;
        n_count    = r_count;
        n_steps    = r_steps;
        n_started  = r_started;
        res_parent = '0;
        res_first  = 1'b0;
        res_entry  = 1'b0;
        res_exit   = '0;
        res_bad    = 1'b0;
        x_fwd_we   = 1'b0;
        x_fwd_addr = r_to;
        x_fwd_data = {1'b1, r_walker};
        x_bwd_we   = 1'b0;
        x_bwd_addr = r_walker;
        x_bwd_data = {1'b1, r_to};
        case (r_func)
            FUNC_START: begin
                if (!site_ok) begin
                    res_bad = 1'b1;
                end else begin
                    n_walker   = AddrW'(r_site);
                    n_count    = CntW'(1);
                    n_steps    = '0;
                    n_started  = 1'b1;
                    x_fwd_we   = 1'b1;
                    x_fwd_addr = AddrW'(r_site);
                    x_fwd_data = {1'b1, AddrW'(r_site)};
                    res_parent = AddrW'(r_site);
                end
            end
            FUNC_STEP: begin
                if (!r_started || CmpW'(r_walker) >= n_x) begin
                    res_bad = 1'b1;
                end else if (r_count < r_ns) begin
                    x_bwd_we = 1'b1;
                    n_walker = r_to;
                    n_col    = r_to_col;
                    n_steps  = (r_steps == '1) ? r_steps : r_steps + TIME_W'(1);
                    if (!r_fwd_rdata[AddrW]) begin
                        x_fwd_we   = 1'b1;
                        n_count    = r_count + CntW'(1);
                        res_first  = 1'b1;
                        res_parent = r_walker;
                    end
                end
            end
            FUNC_READ: begin
                if (!site_ok) begin
                    res_bad = 1'b1;
                end else begin
                    if (r_fwd_rdata[AddrW]) begin
                        res_entry  = 1'b1;
                        res_parent = r_fwd_rdata[AddrW-1:0];
                    end
                    res_exit = r_bwd_rdata[AddrW] ? r_bwd_rdata[AddrW-1:0] : AddrW'(r_site);
                end
            end
            default: begin
                res_bad = 1'b1;
            end
        endcase
    end

    always_comb begin
        fwd_we    = 1'b0;
        fwd_waddr = r_clr_addr;
        fwd_wdata = '0;
        bwd_we    = 1'b0;
        bwd_waddr = r_clr_addr;
        bwd_wdata = '0;
        if (r_state == S_CLEAR) begin
            fwd_we = 1'b1;
            bwd_we = 1'b1;
        end else if (exec_fire) begin
            fwd_we    = x_fwd_we;
            fwd_waddr = x_fwd_addr;
            fwd_wdata = x_fwd_data;
            bwd_we    = x_bwd_we;
            bwd_waddr = x_bwd_addr;
            bwd_wdata = x_bwd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        if (in_accept) begin
            r_fwd_rdata <= r_fwd_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bwd_we) begin
            r_bwd_mem[bwd_waddr] <= bwd_wdata;
        end
        if (in_accept) begin
            r_bwd_rdata <= r_bwd_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_side       <= SIDE_RESET;
            r_walker     <= '0;
            r_col        <= '0;
            r_count      <= '0;
            r_steps      <= '0;
            r_started    <= 1'b0;
            r_col_dirty  <= 1'b0;
            r_start_pend <= 1'b0;
            r_clr_addr   <= '0;
            r_div_cnt    <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_ns <= CntW'(CntW'(side_use) * CntW'(side_use));
            if (!i_out_stall && !exec_fire) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (r_col_dirty) begin
                        r_state      <= S_DIV;
                        r_div_src    <= r_walker;
                        r_div_cnt    <= '0;
                        r_rem        <= '0;
                        r_start_pend <= 1'b0;
                    end else if (in_accept) begin
                        r_func   <= t_func'(i_func);
                        r_site   <= i_site;
                        r_to     <= AddrW'(nb_x);
                        r_to_col <= nb_col;
                        if (i_func == FUNC_START && CmpW'(i_site) < CmpW'(r_ns)) begin
                            r_state      <= S_CLEAR;
                            r_clr_addr   <= '0;
                            r_start_pend <= 1'b1;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AddrW'(1);
                    if (r_clr_addr == AddrW'(Depth - 1)) begin
                        if (r_start_pend) begin
                            r_state   <= S_DIV;
                            r_div_src <= AddrW'(r_site);
                            r_div_cnt <= '0;
                            r_rem     <= '0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    r_rem     <= SideW'(div_next);
                    r_div_src <= r_div_src << 1;
                    r_div_cnt <= r_div_cnt + DivCntW'(1);
                    if (r_div_cnt == DivCntW'(AddrW - 1)) begin
                        r_col   <= SideW'(div_next);
                        r_state <= r_start_pend ? S_EXEC : S_IDLE;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state      <= S_IDLE;
                        r_start_pend <= 1'b0;
                        r_walker     <= n_walker;
                        r_col        <= n_col;
                        r_count      <= n_count;
                        r_steps      <= n_steps;
                        r_started    <= n_started;
                        r_o_valid    <= 1'b1;
                        r_o_current  <= SITE_W'(n_walker);
                        r_o_parent   <= SITE_W'(res_parent);
                        r_o_first    <= res_first;
                        r_o_entry    <= res_entry;
                        r_o_exit     <= SITE_W'(res_exit);
                        r_o_size     <= SIZE_W'(n_count);
                        r_o_time     <= n_steps;
                        r_o_covered  <= n_started && (CmpW'(n_count) >= n_x);
                        r_o_bad      <= res_bad;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (cfg_write) begin
                r_side      <= pwdata[SIDE_REG_W-1:0];
                r_col_dirty <= 1'b1;
            end else if (r_state == S_DIV && r_div_cnt == DivCntW'(AddrW - 1)) begin
                r_col_dirty <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_current_site = r_o_current;
    assign o_parent_site  = r_o_parent;
    assign o_first_visit  = r_o_first;
    assign o_entry_valid  = r_o_entry;
    assign o_exit_site    = r_o_exit;
    assign o_tree_size    = r_o_size;
    assign o_cover_time   = r_o_time;
    assign o_covered      = r_o_covered;
    assign o_bad_request  = r_o_bad;

    `ASSERT_IMPLY(a_started_count, i_clk, i_rst_n, r_started, r_count != '0, "empty started tree")
    `ASSERT_NEXT(a_exec_emits, i_clk, i_rst_n, exec_fire, o_out_valid, "result word lost")
    `ASSERT_IMPLY(a_col_range, i_clk, i_rst_n, r_state == S_IDLE && !r_col_dirty, r_col < side_use, "column out of range")
    `ASSERT_NEXT(a_read_direct, i_clk, i_rst_n, in_accept && i_func == FUNC_READ, r_state == S_EXEC, "read left the direct path")

endmodule

### tb/spanning_tree_checker.sv
// ----------------------------------------------------------------------------
// spanning_tree_checker
// Watches the request, result and configuration channels of the random-walk
// spanning-tree core. It keeps its own copy of the walker, visit marks and
// tree tables, predicts each result word, and compares it field by field
// with what the core returns.
// ----------------------------------------------------------------------------
module spanning_tree_checker
    import rwst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [SITE_W-1:0]     i_site,
    input  logic [DIR_W-1:0]      i_direction,

    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [SITE_W-1:0]     i_current_site,
    input  logic [SITE_W-1:0]     i_parent_site,
    input  logic                  i_first_visit,
    input  logic                  i_entry_valid,
    input  logic [SITE_W-1:0]     i_exit_site,
    input  logic [SIZE_W-1:0]     i_tree_size,
    input  logic [TIME_W-1:0]     i_cover_time,
    input  logic                  i_covered,
    input  logic                  i_bad_request,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    input  logic [APB_DW-1:0]     prdata,
    input  logic                  pready,

    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_trees_covered
);

    localparam int MAX_SITES = MAX_SIDE_DEF * MAX_SIDE_DEF;

    typedef struct packed {
        logic [SITE_W-1:0] current_site;
        logic [SITE_W-1:0] parent_site;
        logic              first_visit;
        logic              entry_valid;
        logic [SITE_W-1:0] exit_site;
        logic [SIZE_W-1:0] tree_size;
        logic [TIME_W-1:0] cover_time;
        logic              covered;
        logic              bad_request;
    } t_walk_word;

    t_walk_word            expected_words[$];

    logic [SIDE_REG_W-1:0] side_reg;
    logic [SITE_W-1:0]     walker;
    logic [SIZE_W-1:0]     tree_count;
    logic [TIME_W-1:0]     steps;
    logic                  started;
    logic                  site_seen    [MAX_SITES];
    logic                  site_left    [MAX_SITES];
    logic [SITE_W-1:0]     parent_of    [MAX_SITES];
    logic [SITE_W-1:0]     last_exit_of [MAX_SITES];

    task automatic clear_marks();
        for (int i = 0; i < MAX_SITES; i++) begin
            site_seen[i] = 1'b0;
            site_left[i] = 1'b0;
        end
    endtask

    task automatic walk_predict(input logic [FUNC_W-1:0] f, input logic [SITE_W-1:0] s,
                                input logic [DIR_W-1:0] d, output t_walk_word w);
        int unsigned side;
        int unsigned ns;
        int unsigned row;
        int unsigned col;
        int unsigned nxt;
        side = 32'(side_reg);
        if (side < MIN_SIDE) side = MIN_SIDE;
        if (side > MAX_SIDE_DEF) side = MAX_SIDE_DEF;
        ns = side * side;
        w = '0;
        case (f)
            FUNC_START: begin
                if (s >= ns) begin
                    w.bad_request = 1'b1;
                end else begin
                    clear_marks();
                    walker = s;
                    site_seen[s] = 1'b1;
                    parent_of[s] = s;
                    tree_count = SIZE_W'(1);
                    steps = '0;
                    started = 1'b1;
                    w.parent_site = s;
                end
            end
            FUNC_STEP: begin
                if (!started || walker >= ns) begin
                    w.bad_request = 1'b1;
                end else if (tree_count < ns) begin
                    row = walker / side;
                    col = walker % side;
                    case (d)
                        DIR_RIGHT: nxt = row * side + (col + 1) % side;
                        DIR_LEFT:  nxt = row * side + (col + side - 1) % side;
                        DIR_UP:    nxt = (walker + side) % ns;
                        default:   nxt = (walker + ns - side) % ns;
                    endcase
                    site_left[walker] = 1'b1;
                    last_exit_of[walker] = SITE_W'(nxt);
                    if (steps != '1) steps = steps + TIME_W'(1);
                    if (!site_seen[nxt]) begin
                        site_seen[nxt] = 1'b1;
                        parent_of[nxt] = walker;
                        tree_count = tree_count + SIZE_W'(1);
                        w.first_visit = 1'b1;
                        w.parent_site = walker;
                    end
                    walker = SITE_W'(nxt);
                end
            end
            FUNC_READ: begin
                if (s >= ns) begin
                    w.bad_request = 1'b1;
                end else begin
                    if (site_seen[s]) begin
                        w.entry_valid = 1'b1;
                        w.parent_site = parent_of[s];
                    end
                    w.exit_site = site_left[s] ? last_exit_of[s] : s;
                end
            end
            default: begin
                w.bad_request = 1'b1;
            end
        endcase
        w.current_site = walker;
        w.tree_size    = tree_count;
        w.cover_time   = steps;
        w.covered      = started && (tree_count >= ns);
    endtask

    task automatic compare_word(input t_walk_word exp, input t_walk_word got);
        if (got.current_site !== exp.current_site) begin
            $error("current_site: expected %0d, got %0d", exp.current_site, got.current_site);
            o_fail_count++;
        end
        if (got.parent_site !== exp.parent_site) begin
            $error("parent_site: expected %0d, got %0d", exp.parent_site, got.parent_site);
            o_fail_count++;
        end
        if (got.first_visit !== exp.first_visit) begin
            $error("first_visit: expected %0d, got %0d", exp.first_visit, got.first_visit);
            o_fail_count++;
        end
        if (got.entry_valid !== exp.entry_valid) begin
            $error("entry_valid: expected %0d, got %0d", exp.entry_valid, got.entry_valid);
            o_fail_count++;
        end
        if (got.exit_site !== exp.exit_site) begin
            $error("exit_site: expected %0d, got %0d", exp.exit_site, got.exit_site);
            o_fail_count++;
        end
        if (got.tree_size !== exp.tree_size) begin
            $error("tree_size: expected %0d, got %0d", exp.tree_size, got.tree_size);
            o_fail_count++;
        end
        if (got.cover_time !== exp.cover_time) begin
            $error("cover_time: expected %0d, got %0d", exp.cover_time, got.cover_time);
            o_fail_count++;
        end
        if (got.covered !== exp.covered) begin
            $error("covered: expected %0d, got %0d", exp.covered, got.covered);
            o_fail_count++;
        end
        if (got.bad_request !== exp.bad_request) begin
            $error("bad_request: expected %0d, got %0d", exp.bad_request, got.bad_request);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_checked       = 0;
        o_trees_covered = 0;
    end

    always @(posedge i_clk) begin
        t_walk_word got;
        t_walk_word exp;
        if (!i_rst_n) begin
            side_reg   = SIDE_RESET;
            walker     = '0;
            tree_count = '0;
            steps      = '0;
            started    = 1'b0;
            clear_marks();
            expected_words.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == ADDR_SIDE) side_reg = pwdata[SIDE_REG_W-1:0];
                end else if (paddr == ADDR_SIDE &&
                             prdata !== {{(APB_DW-SIDE_REG_W){1'b0}}, side_reg}) begin
                    $error("lattice_side: expected %0d, got %0d", side_reg, prdata);
                    o_fail_count++;
                end
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got.current_site = i_current_site;
                got.parent_site  = i_parent_site;
                got.first_visit  = i_first_visit;
                got.entry_valid  = i_entry_valid;
                got.exit_site    = i_exit_site;
                got.tree_size    = i_tree_size;
                got.cover_time   = i_cover_time;
                got.covered      = i_covered;
                got.bad_request  = i_bad_request;
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: site %0d", i_current_site);
                    o_fail_count++;
                end else begin
                    exp = expected_words.pop_front();
                    compare_word(exp, got);
                    o_checked++;
                    if (exp.covered && exp.first_visit) o_trees_covered++;
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                walk_predict(i_func, i_site, i_direction, exp);
                expected_words.push_back(exp);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the random-walk spanning-tree core: a directed opening through the
// lattice corners, wraparound, coverage and rejected requests, then random
// walks over many lattice sides with random gaps and result stalls. A
// separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    import rwst_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
    localparam logic [SITE_W-1:0] TOP_SITE     = 12'd4095;
    localparam int                PHASE_WORDS  = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [FUNC_W-1:0]     func;
    logic [SITE_W-1:0]     site;
    logic [DIR_W-1:0]      direction;
    logic                  out_valid;
    logic                  out_stall;
    logic [SITE_W-1:0]     current_site;
    logic [SITE_W-1:0]     parent_site;
    logic                  first_visit;
    logic                  entry_valid;
    logic [SITE_W-1:0]     exit_site;
    logic [SIZE_W-1:0]     tree_size;
    logic [TIME_W-1:0]     cover_time;
    logic                  covered;
    logic                  bad_request;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    int                    checked;
    int                    trees_covered;
    int                    words_sent;
    int                    settings_written;
    int unsigned           site_total;
    logic                  idle_on;

    random_walk_spanning_tree_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_func         (func),
        .i_site         (site),
        .i_direction    (direction),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_current_site (current_site),
        .o_parent_site  (parent_site),
        .o_first_visit  (first_visit),
        .o_entry_valid  (entry_valid),
        .o_exit_site    (exit_site),
        .o_tree_size    (tree_size),
        .o_cover_time   (cover_time),
        .o_covered      (covered),
        .o_bad_request  (bad_request),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    spanning_tree_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_func          (func),
        .i_site          (site),
        .i_direction     (direction),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_current_site  (current_site),
        .i_parent_site   (parent_site),
        .i_first_visit   (first_visit),
        .i_entry_valid   (entry_valid),
        .i_exit_site     (exit_site),
        .i_tree_size     (tree_size),
        .i_cover_time    (cover_time),
        .i_covered       (covered),
        .i_bad_request   (bad_request),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_trees_covered (trees_covered)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #10000000;
        $error("timeout with %0d result words outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [SITE_W-1:0] s,
                             input logic [DIR_W-1:0] d);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        site      <= s;
        direction <= d;
        do @(posedge clk); while (!(in_valid && in_stall === 1'b0));
        words_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [SIDE_REG_W-1:0] val);
        logic [APB_DW-1:0] word;
        int unsigned       side;
        word = $urandom();
        word[SIDE_REG_W-1:0] = val;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_SIDE;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (wr) begin
            side = 32'(val);
            if (side < MIN_SIDE) side = MIN_SIDE;
            if (side > MAX_SIDE_DEF) side = MAX_SIDE_DEF;
            site_total = side * side;
            settings_written++;
        end
    endtask

    task automatic set_side(input logic [SIDE_REG_W-1:0] val);
        drain();
        apb_access(1'b1, val);
        apb_access(1'b0, val);
    endtask

    // stall the result side a random number of cycles per word
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            n = idle_on ? $urandom_range(0, 15) : 0;
            if (n > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
        end
    end

    initial begin
        logic [SIDE_REG_W-1:0] sides [14];
        int                    n;
        int                    r;
        sides = '{7'd2, 7'd3, 7'd4, 7'd5, 7'd0, 7'd8, 7'd6,
                  7'd16, 7'd1, 7'd64, 7'd127, 7'd3, 7'd33, 7'd2};
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        func             = FUNC_START;
        site             = '0;
        direction        = DIR_RIGHT;
        out_stall        = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = ADDR_SIDE;
        pwdata           = '0;
        words_sent       = 0;
        settings_written = 0;
        site_total       = MAX_SIDE_DEF * MAX_SIDE_DEF;
        idle_on          = 1'b1;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // no tree yet, full-size lattice
        send_word(FUNC_STEP, '0, DIR_RIGHT);
        send_word(FUNC_READ, '0, DIR_LEFT);
        send_word(FUNC_READ, TOP_SITE, DIR_UP);
        send_word(FUNC_UNKNOWN, TOP_SITE, DIR_DOWN);
        // corner start, wrap in all four directions
        send_word(FUNC_START, TOP_SITE, DIR_UP);
        send_word(FUNC_STEP, '0, DIR_RIGHT);
        send_word(FUNC_STEP, TOP_SITE, DIR_LEFT);
        send_word(FUNC_STEP, '0, DIR_UP);
        send_word(FUNC_STEP, TOP_SITE, DIR_DOWN);
        send_word(FUNC_READ, TOP_SITE, DIR_RIGHT);
        send_word(FUNC_READ, 12'd4032, DIR_RIGHT);
        send_word(FUNC_READ, '0, DIR_RIGHT);
        // shrink the lattice under the walker
        set_side(7'd0);
        send_word(FUNC_STEP, '0, DIR_RIGHT);
        send_word(FUNC_READ, 12'd4, DIR_RIGHT);
        send_word(FUNC_START, 12'd4, DIR_RIGHT);
        send_word(FUNC_START, 12'd3, DIR_RIGHT);
        send_word(FUNC_STEP, '0, DIR_RIGHT);
        send_word(FUNC_STEP, '0, DIR_UP);
        send_word(FUNC_STEP, '0, DIR_RIGHT);
        send_word(FUNC_STEP, '0, DIR_DOWN);
        send_word(FUNC_READ, 12'd1, DIR_LEFT);
        // grow again past the largest side
        set_side(7'd127);
        send_word(FUNC_STEP, '0, DIR_UP);
        send_word(FUNC_READ, TOP_SITE, DIR_DOWN);

        for (int p = 0; p < 14; p++) begin
            set_side(sides[p]);
            idle_on = (p % 3 != 1);
            send_word(FUNC_START, SITE_W'($urandom_range(0, site_total - 1)),
                      DIR_W'($urandom_range(0, 3)));
            n = 0;
            while (n < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 62) begin
                    send_word(FUNC_STEP, SITE_W'($urandom_range(0, 4095)),
                              DIR_W'($urandom_range(0, 3)));
                    n++;
                end else if (r < 82) begin
                    send_word(FUNC_READ, SITE_W'($urandom_range(0, site_total - 1)),
                              DIR_W'($urandom_range(0, 3)));
                    n++;
                end else if (r < 85) begin
                    send_word(FUNC_START, SITE_W'($urandom_range(0, site_total - 1)),
                              DIR_W'($urandom_range(0, 3)));
                    n++;
                end else begin
                    send_word(FUNC_W'($urandom_range(0, 3)), SITE_W'($urandom_range(0, 4095)),
                              DIR_W'($urandom_range(0, 3)));
                end
            end
        end
        drain();

        $display("sent %0d request words across %0d lattice side settings",
                 words_sent, settings_written);
        $display("compared %0d result words, %0d trees walked to full coverage",
                 checked, trees_covered);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
